>>> hw/rtl/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types, constants and helpers of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

	localparam int COORD_BITS     = 12;
	localparam int WIDTH_BITS     = 13;
	localparam int ADDR_BITS      = 32;
	localparam int COLOUR_BITS    = 32;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int ERR_BITS       = COORD_BITS + 2;
	localparam int IN_DATA_BITS   = 4 * COORD_BITS;
	localparam int OUT_DATA_BITS  = 2 * COORD_BITS + ADDR_BITS + COLOUR_BITS;
	localparam int OUT_USER_BITS  = 2;
	localparam int IDX_BITS       = COORD_BITS + WIDTH_BITS + 1;

	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

	localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RST = WIDTH_BITS'(640);
	localparam logic [ADDR_BITS-1:0]   FRAME_BASE_RST  = '0;
	localparam logic [COLOUR_BITS-1:0] FG_COLOUR_RST   = '1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_FRAME_WIDTH = 2'd0,
		CFG_FRAME_BASE  = 2'd1,
		CFG_FG_COLOUR   = 2'd2
	} cfg_index_t;

	typedef enum logic {
		ACTION_START = 1'b0,
		ACTION_STEP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'b00,
		DIR_POS  = 2'b01,
		DIR_NEG  = 2'b11
	} dir_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   write_valid;
		logic   line_end;
		logic   last;
	} pix_rec_t;

	function automatic dir_t dir_of(input coord_t from_c, input coord_t to_c);
		dir_t d;
		if (to_c > from_c) begin
			d = DIR_POS;
		end else if (to_c < from_c) begin
			d = DIR_NEG;
		end else begin
			d = DIR_NONE;
		end
		return d;
	endfunction

	function automatic coord_t step_coord(input coord_t c, input dir_t d);
		coord_t r;
		case (d)
			DIR_POS: r = c + 1'b1;
			DIR_NEG: r = c - 1'b1;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/line_pixel_generator.sv
// ----------------------------------------------------------------------------
// line_pixel_generator
// Step-wise Bresenham line rasterizer with 4-connected pixel output.
// ----------------------------------------------------------------------------
// A start request (tuser 0) loads both end points and emits the start pixel;
// each step request (tuser 1) runs one Bresenham pass and emits one or two
// pixels, the second one when x and y both move. Every request is handled in
// the cycle it is taken, so a new request can be taken every cycle while the
// pixel queue has two free entries; pixels leave at one per cycle, while the
// receiver is ready, through a four-entry pixel queue and an output register.
// A step after the line has ended gives one result with write_valid low, tlast
// high and all other fields zero. Configuration must be written only while the
// block is idle; the block itself does not enforce this.
module line_pixel_generator import lpg_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_DATA_BITS-1:0]   s_tdata,   // start_x, start_y, end_x, end_y
	input  logic [0:0]                s_tuser,   // action
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [OUT_DATA_BITS-1:0]  m_tdata,   // pixel_x, pixel_y, pixel_address, pixel_colour
	output logic [OUT_USER_BITS-1:0]  m_tuser,   // write_valid, line_end
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic [WIDTH_BITS-1:0]  frame_width_q;
	logic [ADDR_BITS-1:0]   frame_base_q;
	logic [COLOUR_BITS-1:0] fg_colour_q;

	coord_t                 cur_x_q, cur_y_q, target_x_q, target_y_q, delta_x_q, delta_y_q;
	dir_t                   dir_x_q, dir_y_q;
	logic [ERR_BITS-1:0]    error_term_q;
	logic                   active_q;

	coord_t                 in_sx, in_sy, in_ex, in_ey;
	logic                   in_accept;
	logic                   in_start;

	coord_t                 st_dx, st_dy;
	logic                   st_zero;

	logic signed [ERR_BITS:0] e2, neg_dy, pos_dx;
	logic                   move_x, move_y;
	coord_t                 nx, ny;
	logic [ERR_BITS-1:0]    err_next;

	pix_rec_t               rec_a, rec_b;
	logic                   push_two;

	pix_rec_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;
	logic [FIFO_CNT_BITS-1:0] push_n;
	logic                   pop;
	pix_rec_t               head;

	logic [2*COORD_BITS:0]  row_off;
	logic [IDX_BITS-1:0]    pix_idx;
	logic [ADDR_BITS-1:0]   head_addr;
	logic [COLOUR_BITS-1:0] head_colour;

	logic                   out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;
	logic [OUT_USER_BITS-1:0] out_user_q;
	logic                   out_last_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_WIDTH_RST;
			frame_base_q  <= FRAME_BASE_RST;
			fg_colour_q   <= FG_COLOUR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data[WIDTH_BITS-1:0];
				CFG_FRAME_BASE:  frame_base_q  <= cfg_data[ADDR_BITS-1:0];
				CFG_FG_COLOUR:   fg_colour_q   <= cfg_data[COLOUR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// request fields
	assign in_sx     = s_tdata[COORD_BITS-1:0];
	assign in_sy     = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign in_ex     = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign in_ey     = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
	assign in_start  = (s_tuser[0] == ACTION_START);
	assign s_tready  = (cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
	assign in_accept = s_tvalid && s_tready;

	// line setup
	assign st_dx   = (in_ex >= in_sx) ? in_ex - in_sx : in_sx - in_ex;
	assign st_dy   = (in_ey >= in_sy) ? in_ey - in_sy : in_sy - in_ey;
	assign st_zero = (in_sx == in_ex) && (in_sy == in_ey);

	// one bresenham pass
	assign e2     = $signed({error_term_q, 1'b0});
	assign neg_dy = -$signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, delta_y_q});
	assign pos_dx = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, delta_x_q});
	assign move_x = e2 > neg_dy;
	assign move_y = e2 < pos_dx;
	assign nx     = move_x ? step_coord(cur_x_q, dir_x_q) : cur_x_q;
	assign ny     = move_y ? step_coord(cur_y_q, dir_y_q) : cur_y_q;

	always_comb begin
		err_next = error_term_q;
		if (move_x) begin
			err_next = err_next - {{(ERR_BITS-COORD_BITS){1'b0}}, delta_y_q};
		end
		if (move_y) begin
			err_next = err_next + {{(ERR_BITS-COORD_BITS){1'b0}}, delta_x_q};
		end
	end

	// pixel records for this request
	always_comb begin
		rec_a    = '0;
		rec_b    = '0;
		push_two = 1'b0;
		rec_a.last = 1'b1;
		rec_b.last = 1'b1;
		if (in_start) begin
			rec_a.x           = in_sx;
			rec_a.y           = in_sy;
			rec_a.write_valid = 1'b1;
			rec_a.line_end    = st_zero;
		end else if (active_q && (move_x || move_y)) begin
			rec_b.x           = nx;
			rec_b.y           = ny;
			rec_b.write_valid = 1'b1;
			rec_b.line_end    = (nx == target_x_q) && (ny == target_y_q);
			if (move_x) begin
				rec_a.x           = nx;
				rec_a.y           = cur_y_q;
				rec_a.write_valid = 1'b1;
				rec_a.line_end    = (nx == target_x_q) && (cur_y_q == target_y_q);
				rec_a.last        = !move_y;
				push_two          = move_y;
			end else begin
				rec_a = rec_b;
			end
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			delta_x_q    <= '0;
			delta_y_q    <= '0;
			dir_x_q      <= DIR_NONE;
			dir_y_q      <= DIR_NONE;
			error_term_q <= '0;
			active_q     <= 1'b0;
		end else if (in_accept) begin
			if (in_start) begin
				cur_x_q      <= in_sx;
				cur_y_q      <= in_sy;
				target_x_q   <= in_ex;
				target_y_q   <= in_ey;
				delta_x_q    <= st_dx;
				delta_y_q    <= st_dy;
				dir_x_q      <= dir_of(in_sx, in_ex);
				dir_y_q      <= dir_of(in_sy, in_ey);
				error_term_q <= {{(ERR_BITS-COORD_BITS){1'b0}}, st_dx}
				              - {{(ERR_BITS-COORD_BITS){1'b0}}, st_dy};
				active_q     <= !st_zero;
			end else if (active_q) begin
				cur_x_q      <= nx;
				cur_y_q      <= ny;
				error_term_q <= err_next;
				active_q     <= (move_x || move_y) && !((nx == target_x_q) && (ny == target_y_q));
			end
		end
	end

	// pixel queue
	assign push_n = in_accept ? (push_two ? FIFO_CNT_BITS'(2) : FIFO_CNT_BITS'(1))
	                          : FIFO_CNT_BITS'(0);
	assign pop    = (cnt_q != '0) && (!out_valid_q || m_tready);
	assign head   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (in_accept) begin
			fifo_q[wr_ptr_q] <= rec_a;
			if (push_two) begin
				fifo_q[wr_ptr_q + 1'b1] <= rec_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push_n);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(pop);
			cnt_q    <= cnt_q + push_n - FIFO_CNT_BITS'(pop);
		end
	end

	// address of the head pixel
	assign row_off = {{(COORD_BITS+1){1'b0}}, head.y} * {{COORD_BITS{1'b0}}, frame_width_q};
	assign pix_idx = IDX_BITS'(row_off) + IDX_BITS'(head.x);

	always_comb begin
		head_addr   = '0;
		head_colour = '0;
		if (head.write_valid) begin
			head_addr   = frame_base_q + ADDR_BITS'({pix_idx, 2'b00});
			head_colour = fg_colour_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= {head_colour, head_addr, head.y, head.x};
			out_user_q <= {head.line_end, head.write_valid};
			out_last_q <= head.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

>>> hw/rtl/lpg_check.sv
// ----------------------------------------------------------------------------
// lpg_check
// Port-level checks of the line pixel generator, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_check import lpg_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [OUT_DATA_BITS-1:0]  m_tdata,
	input logic [OUT_USER_BITS-1:0]  m_tuser,
	input logic                      m_tlast
);

	// a result with no write is a lone, all-zero result
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == '0) && m_tlast && !m_tuser[1])
		else $error("non-write result carries data");

	// end of line only on a written pixel
	a_end_written: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0])
		else $error("line end on non-write result");

	// second pixel of a request follows right after the first
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[0] && m_tlast)
		else $error("second pixel of a step missing");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

endmodule

bind line_pixel_generator lpg_check u_lpg_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

>>> sim/line_pixel_generator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_generator_tb
// Self-checking bench for the step-wise line rasterizer.
// ----------------------------------------------------------------------------
// Start and step requests are sent over the input stream in random bursts while
// the pixel stream stalls on its own random pattern. A built-in line tracer
// predicts every pixel (coordinates, address, colour, flags) at the moment a
// request is taken, and each pixel that leaves the block is checked against the
// oldest prediction. The directed lines run at reset values; the phases then
// write frame settings between them while the block is drained: extreme pitch,
// base and colour values, a zero pitch, an unused register index and random ones.
module line_pixel_generator_tb;
	import lpg_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 212;
	localparam int NUM_PHASES  = 8;
	localparam int SHOW_LIMIT  = 10;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef struct {
		action_t action;
		coord_t  sx;
		coord_t  sy;
		coord_t  ex;
		coord_t  ey;
	} line_req_t;

	typedef struct packed {
		coord_t                 x;
		coord_t                 y;
		logic [ADDR_BITS-1:0]   address;
		logic [COLOUR_BITS-1:0] colour;
		logic                   write_valid;
		logic                   line_end;
		logic                   last;
	} pixel_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      s_tvalid  = 1'b0;
	logic                      s_tready;
	logic [IN_DATA_BITS-1:0]   s_tdata   = '0;   // start_x, start_y, end_x, end_y
	logic [0:0]                s_tuser   = '0;   // action
	logic                      m_tvalid;
	logic                      m_tready  = 1'b0;
	logic [OUT_DATA_BITS-1:0]  m_tdata;          // pixel_x, pixel_y, pixel_address, pixel_colour
	logic [OUT_USER_BITS-1:0]  m_tuser;          // write_valid, line_end
	logic                      m_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

	// frame settings as the block should hold them
	logic [WIDTH_BITS-1:0]  pitch_px = FRAME_WIDTH_RST;
	logic [ADDR_BITS-1:0]   fb_base  = FRAME_BASE_RST;
	logic [COLOUR_BITS-1:0] fg_word  = FG_COLOUR_RST;

	// line tracer state
	coord_t pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
	coord_t span_x = '0, span_y = '0;
	dir_t   heading_x = DIR_NONE, heading_y = DIR_NONE;
	int     err_acc = 0;
	bit     drawing = 1'b0;

	line_req_t pending_reqs[$];
	pixel_t    pixel_expect_q[$];
	line_req_t req_now;
	int        reqs_queued    = 0;
	int        reqs_accepted  = 0;
	int        burst_left     = 0;
	int        gap_left       = 0;
	int        ready_left     = 0;
	int        mismatch_count = 0;
	int        cycle_count    = 0;

	line_pixel_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void emit_pixel(input bit is_last);
		pixel_t p;
		logic [31:0] idx;
		idx = 32'(pen_y) * 32'(pitch_px) + 32'(pen_x);
		p.x           = pen_x;
		p.y           = pen_y;
		p.address     = fb_base + idx * 32'd4;
		p.colour      = fg_word;
		p.write_valid = 1'b1;
		p.line_end    = (pen_x == goal_x) && (pen_y == goal_y);
		p.last        = is_last;
		pixel_expect_q.push_back(p);
	endfunction

	function automatic void emit_idle_result();
		pixel_t p;
		p      = '0;
		p.last = 1'b1;
		pixel_expect_q.push_back(p);
	endfunction

	function automatic coord_t advance(input coord_t c, input dir_t d);
		if (d == DIR_POS) begin
			return c + 1'b1;
		end else if (d == DIR_NEG) begin
			return c - 1'b1;
		end
		return c;
	endfunction

	function automatic dir_t heading(input coord_t from_c, input coord_t to_c);
		if (to_c > from_c) begin
			return DIR_POS;
		end else if (to_c < from_c) begin
			return DIR_NEG;
		end
		return DIR_NONE;
	endfunction

	// expected pixels of one taken request
	function automatic void rasterize_request(input line_req_t r);
		int  e2;
		bit  move_x;
		bit  move_y;
		if (r.action == ACTION_START) begin
			pen_x     = r.sx;
			pen_y     = r.sy;
			goal_x    = r.ex;
			goal_y    = r.ey;
			span_x    = (r.ex >= r.sx) ? r.ex - r.sx : r.sx - r.ex;
			span_y    = (r.ey >= r.sy) ? r.ey - r.sy : r.sy - r.ey;
			heading_x = heading(r.sx, r.ex);
			heading_y = heading(r.sy, r.ey);
			err_acc   = int'(span_x) - int'(span_y);
			drawing   = !(r.sx == r.ex && r.sy == r.ey);
			emit_pixel(1'b1);
		end else if (!drawing) begin
			emit_idle_result();
		end else begin
			e2     = 2 * err_acc;
			move_x = e2 > -int'(span_y);
			move_y = e2 < int'(span_x);
			if (move_x) begin
				err_acc = err_acc - int'(span_y);
				pen_x   = advance(pen_x, heading_x);
				emit_pixel(!move_y);
			end
			if (move_y) begin
				err_acc = err_acc + int'(span_x);
				pen_y   = advance(pen_y, heading_y);
				emit_pixel(1'b1);
			end
			drawing = !(pen_x == goal_x && pen_y == goal_y);
			if (!move_x && !move_y) begin
				emit_idle_result();
				drawing = 1'b0;
			end
		end
	endfunction

	// request driver: bursts of random length with random gaps
	always @(posedge clk or negedge arst_n) begin
		logic take;
		logic valid_nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			take      = s_tvalid && s_tready;
			valid_nxt = s_tvalid;
			if (take) begin
				rasterize_request(req_now);
				reqs_accepted++;
			end
			if (take || !s_tvalid) begin
				valid_nxt = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					req_now   = pending_reqs.pop_front();
					valid_nxt = 1'b1;
					s_tdata  <= {req_now.ey, req_now.ex, req_now.sy, req_now.sx};
					s_tuser  <= req_now.action;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst_left--;
					end
				end
				s_tvalid <= valid_nxt;
			end
		end
	end

	// pixel monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		pixel_t got;
		pixel_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (ready_left == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					m_tready  <= 1'b0;
					ready_left = $urandom_range(1, 6);
				end else begin
					m_tready  <= 1'b1;
					ready_left = $urandom_range(1, 30);
				end
			end else begin
				ready_left--;
			end
			if (m_tvalid && m_tready) begin
				got.x           = m_tdata[11:0];
				got.y           = m_tdata[23:12];
				got.address     = m_tdata[55:24];
				got.colour      = m_tdata[87:56];
				got.write_valid = m_tuser[0];
				got.line_end    = m_tuser[1];
				got.last        = m_tlast;
				if (pixel_expect_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_LIMIT)
						$display("unexpected pixel x=%0d y=%0d addr=%h", got.x, got.y,
							got.address);
				end else begin
					want = pixel_expect_q.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= SHOW_LIMIT) begin
							$display("pixel mismatch: expected x=%0d y=%0d addr=%h colour=%h %b%b%b",
								want.x, want.y, want.address, want.colour,
								want.write_valid, want.line_end, want.last);
							$display("                got      x=%0d y=%0d addr=%h colour=%h %b%b%b",
								got.x, got.y, got.address, got.colour,
								got.write_valid, got.line_end, got.last);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FRAME_WIDTH: pitch_px = value[WIDTH_BITS-1:0];
			CFG_FRAME_BASE:  fb_base  = value;
			CFG_FG_COLOUR:   fg_word  = value;
			default: ;
		endcase
	endtask

	task automatic queue_req(input action_t a, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey);
		line_req_t r;
		r.action = a;
		r.sx     = sx;
		r.sy     = sy;
		r.ex     = ex;
		r.ey     = ey;
		pending_reqs.push_back(r);
		reqs_queued++;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (reqs_accepted != reqs_queued || pixel_expect_q.size() != 0);
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom_range(0, 4095));
	endfunction

	function automatic coord_t nearby(input coord_t c, input int d);
		if ($urandom_range(0, 1) == 1 && int'(c) + d <= 4095) begin
			return coord_t'(int'(c) + d);
		end else if (int'(c) >= d) begin
			return coord_t'(int'(c) - d);
		end
		return coord_t'(int'(c) + d);
	endfunction

	initial begin
		int     n;
		int     kind;
		int     reach;
		int     steps;
		coord_t sx, sy, ex, ey;
		logic [WIDTH_BITS-1:0] w;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at reset settings
		queue_req(ACTION_STEP, 12'd1, 12'd2, 12'd3, 12'd4);
		queue_req(ACTION_START, 12'd0, 12'd0, 12'd0, 12'd0);
		queue_req(ACTION_STEP, 12'd0, 12'd0, 12'd0, 12'd0);
		queue_req(ACTION_START, 12'd0, 12'd0, 12'd4095, 12'd4095);
		repeat (3) queue_req(ACTION_STEP, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		queue_req(ACTION_START, 12'd4095, 12'd0, 12'd0, 12'd4095);
		repeat (3) queue_req(ACTION_STEP, 12'd0, 12'd0, 12'd0, 12'd0);
		queue_req(ACTION_START, 12'd10, 12'd5, 12'd14, 12'd5);
		repeat (5) queue_req(ACTION_STEP, 12'd0, 12'd0, 12'd0, 12'd0);
		queue_req(ACTION_START, 12'd7, 12'd9, 12'd7, 12'd6);
		repeat (4) queue_req(ACTION_STEP, 12'd0, 12'd0, 12'd0, 12'd0);
		queue_req(ACTION_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		wait_drained();

		for (int p = 1; p <= NUM_PHASES; p++) begin
			case (p)
				1: begin
					w = 13'd1;
					write_reg(CFG_FRAME_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(w));
					write_reg(CFG_FRAME_BASE, 32'hFFFF_FFFF);
					write_reg(CFG_FG_COLOUR, 32'h0000_0000);
				end
				2: begin
					w = 13'd4096;
					write_reg(CFG_FRAME_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(w));
					write_reg(CFG_FRAME_BASE, 32'h0000_0000);
					write_reg(CFG_FG_COLOUR, 32'hFFFF_FFFF);
				end
				3: begin
					// zero pitch collapses the row term
					w = 13'd0;
					write_reg(CFG_FRAME_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(w));
					write_reg(CFG_FRAME_BASE, $urandom);
					write_reg(CFG_FG_COLOUR, $urandom);
					write_reg(CFG_SPARE_INDEX, $urandom);
				end
				default: begin
					w = WIDTH_BITS'($urandom_range(1, 4096));
					write_reg(CFG_FRAME_WIDTH, ($urandom & 32'hFFFF_E000) | 32'(w));
					write_reg(CFG_FRAME_BASE, $urandom);
					write_reg(CFG_FG_COLOUR, $urandom);
				end
			endcase
			cfg_valid <= 1'b0;

			n = 0;
			while (n < PHASE_ITEMS) begin
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					// noise
					queue_req(action_t'($urandom_range(0, 1)), rand_coord(),
						rand_coord(), rand_coord(), rand_coord());
					n++;
				end else begin
					sx = rand_coord();
					sy = rand_coord();
					if (kind == 9) begin
						ex    = rand_coord();
						ey    = rand_coord();
						steps = $urandom_range(1, 20);
					end else begin
						reach = (kind >= 7) ? 60 : 12;
						ex    = nearby(sx, $urandom_range(0, reach));
						ey    = nearby(sy, $urandom_range(0, reach));
						steps = int'(ex >= sx ? ex - sx : sx - ex)
							+ int'(ey >= sy ? ey - sy : sy - ey) + $urandom_range(0, 2);
						if ($urandom_range(0, 7) == 0)
							steps = $urandom_range(0, steps);
					end
					queue_req(ACTION_START, sx, sy, ex, ey);
					repeat (steps) queue_req(ACTION_STEP, rand_coord(),
						rand_coord(), rand_coord(), rand_coord());
					n += steps + 1;
				end
			end
			wait_drained();
		end

		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
